// ----- hw/rtl/nnis_pkg.sv -----
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants for the nearest neighbor image scaler: field
// widths, command and register codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

  // parameter defaults
  localparam int MAX_SOURCE_WIDTH_DEF  = 64;
  localparam int MAX_SOURCE_HEIGHT_DEF = 64;
  localparam int COORD_BITS_DEF        = 12;

  // fixed field widths
  localparam int SRC_DIM_BITS    = 7;
  localparam int TGT_DIM_BITS    = 12;
  localparam int ORIGIN_BITS     = 13;
  localparam int SCREEN_BITS     = 13;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 13;
  localparam int LOAD_INDEX_BITS = 12;
  localparam int PIXEL_BITS      = 32;

  // quotient of a source coordinate is below the source size, so 7 bits
  localparam int QUOT_BITS     = SRC_DIM_BITS;
  localparam int STEP_CNT_BITS = 3;
  localparam logic [STEP_CNT_BITS-1:0] DIV_LAST = STEP_CNT_BITS'(QUOT_BITS - 1);

  // input item command
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } item_cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_DIV_X,
    S_MUL_Y,
    S_DIV_Y,
    S_ADDR,
    S_READ,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic mul;
    logic sel_y;
    logic div_step;
    logic calc_addr;
    logic read;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic degenerate;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nnis_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnis_ctrl
// Controller state machine: accepts beats, sequences the x and y divisions,
// address calculation, store read and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  output logic                   in_ready,
  output nnis_pkg::dp_cmd_t      cmd,
  input  wire nnis_pkg::dp_sts_t sts
);

  nnis_pkg::state_t state_r, state_nxt;
  logic [nnis_pkg::STEP_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic is_step;

  assign is_step = (nnis_pkg::item_cmd_t'(in_cmd) == nnis_pkg::CMD_STEP);

  // state and division step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnis_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      nnis_pkg::S_IDLE: begin
        if (in_valid && is_step) state_nxt = nnis_pkg::S_MUL_X;
      end
      nnis_pkg::S_MUL_X: begin
        state_nxt = sts.degenerate ? nnis_pkg::S_OUT : nnis_pkg::S_DIV_X;
      end
      nnis_pkg::S_DIV_X: begin
        if (cnt_r == nnis_pkg::DIV_LAST) state_nxt = nnis_pkg::S_MUL_Y;
        else cnt_nxt = cnt_r + 1'b1;
      end
      nnis_pkg::S_MUL_Y: begin
        state_nxt = nnis_pkg::S_DIV_Y;
      end
      nnis_pkg::S_DIV_Y: begin
        if (cnt_r == nnis_pkg::DIV_LAST) state_nxt = nnis_pkg::S_ADDR;
        else cnt_nxt = cnt_r + 1'b1;
      end
      nnis_pkg::S_ADDR: begin
        state_nxt = nnis_pkg::S_READ;
      end
      nnis_pkg::S_READ: begin
        state_nxt = nnis_pkg::S_OUT;
      end
      nnis_pkg::S_OUT: begin
        if (sts.out_free) state_nxt = nnis_pkg::S_IDLE;
      end
      default: begin
        state_nxt = nnis_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    in_ready      = (state_r == nnis_pkg::S_IDLE);
    cmd           = '0;
    cmd.load      = in_ready && in_valid && !is_step;
    cmd.start     = in_ready && in_valid && is_step;
    cmd.mul       = ((state_r == nnis_pkg::S_MUL_X) && !sts.degenerate) ||
                    (state_r == nnis_pkg::S_MUL_Y);
    cmd.sel_y     = (state_r == nnis_pkg::S_MUL_Y);
    cmd.div_step  = (state_r == nnis_pkg::S_DIV_X) || (state_r == nnis_pkg::S_DIV_Y);
    cmd.calc_addr = (state_r == nnis_pkg::S_ADDR);
    cmd.read      = (state_r == nnis_pkg::S_READ);
    cmd.emit      = (state_r == nnis_pkg::S_OUT) && sts.out_free;
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != nnis_pkg::S_IDLE) |-> !cmd.load && !cmd.start)
    else $error("beat taken while busy");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register occupied");

  a_div_x_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nnis_pkg::S_DIV_X && cnt_r == nnis_pkg::DIV_LAST) |=>
      (state_r == nnis_pkg::S_MUL_Y))
    else $error("x division did not hand over to y");

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_datapath.sv -----
// ----------------------------------------------------------------------------
// nnis_datapath
// Configuration registers, source store, raster counters, shared restoring
// divider for the source coordinates, clipping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_datapath #(
  parameter int MAX_SOURCE_WIDTH  = nnis_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_SOURCE_HEIGHT = nnis_pkg::MAX_SOURCE_HEIGHT_DEF,
  parameter int COORD_BITS        = nnis_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [nnis_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [nnis_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic [nnis_pkg::LOAD_INDEX_BITS-1:0]  in_load_index,
  input  wire logic [nnis_pkg::PIXEL_BITS-1:0]       in_pixel_value,
  input  wire nnis_pkg::dp_cmd_t                     cmd,
  output nnis_pkg::dp_sts_t                          sts,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [COORD_BITS-1:0]                      out_screen_x,
  output logic [COORD_BITS-1:0]                      out_screen_y,
  output logic [nnis_pkg::PIXEL_BITS-1:0]            out_color,
  output logic                                       out_write_enable,
  output logic                                       out_last
);

  localparam int SDW   = nnis_pkg::SRC_DIM_BITS;
  localparam int TDW   = nnis_pkg::TGT_DIM_BITS;
  localparam int QW    = nnis_pkg::QUOT_BITS;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IXW   = ((AW > nnis_pkg::LOAD_INDEX_BITS) ? AW
                          : nnis_pkg::LOAD_INDEX_BITS) + 1;
  localparam int CW    = ((COORD_BITS > TDW) ? COORD_BITS : TDW) + 1;
  localparam int PRW   = COORD_BITS + SDW;
  localparam int DVW   = TDW + QW - 1;
  localparam int CMPW  = (PRW > DVW) ? PRW : DVW;
  localparam int AFW   = (AW > 2 * SDW + 1) ? AW : 2 * SDW + 1;
  localparam int PW    = ((COORD_BITS + 1 > nnis_pkg::ORIGIN_BITS) ? COORD_BITS + 1
                          : nnis_pkg::ORIGIN_BITS) + 1;
  localparam int MAXW  = 12;

  // configuration registers
  logic [SDW-1:0]                      src_w_r, src_h_r;
  logic [TDW-1:0]                      tgt_w_r, tgt_h_r;
  logic [nnis_pkg::ORIGIN_BITS-1:0]    org_x_r, org_y_r;
  logic [nnis_pkg::SCREEN_BITS-1:0]    scr_w_r, scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= '0;
      src_h_r <= '0;
      tgt_w_r <= '0;
      tgt_h_r <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
      scr_w_r <= '0;
      scr_h_r <= '0;
    end else if (cfg_we) begin
      case (nnis_pkg::cfg_reg_t'(cfg_index))
        nnis_pkg::REG_SOURCE_WIDTH:  src_w_r <= cfg_data[SDW-1:0];
        nnis_pkg::REG_SOURCE_HEIGHT: src_h_r <= cfg_data[SDW-1:0];
        nnis_pkg::REG_TARGET_WIDTH:  tgt_w_r <= cfg_data[TDW-1:0];
        nnis_pkg::REG_TARGET_HEIGHT: tgt_h_r <= cfg_data[TDW-1:0];
        nnis_pkg::REG_ORIGIN_X:      org_x_r <= cfg_data;
        nnis_pkg::REG_ORIGIN_Y:      org_y_r <= cfg_data;
        nnis_pkg::REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        nnis_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // source sizes saturated at the store dimensions
  logic [SDW-1:0] sw_c, sh_c;
  assign sw_c = (MAXW'(src_w_r) > MAXW'(MAX_SOURCE_WIDTH))  ? SDW'(MAX_SOURCE_WIDTH)  : src_w_r;
  assign sh_c = (MAXW'(src_h_r) > MAXW'(MAX_SOURCE_HEIGHT)) ? SDW'(MAX_SOURCE_HEIGHT) : src_h_r;

  // source store
  logic [nnis_pkg::PIXEL_BITS-1:0] mem [DEPTH];
  logic [IXW-1:0]                  ld_ext;
  logic [AW-1:0]                   addr_r;
  logic [nnis_pkg::PIXEL_BITS-1:0] rd_data_r;

  assign ld_ext = IXW'(in_load_index);

  always_ff @(posedge clk) begin
    if (cmd.load && (ld_ext < IXW'(DEPTH))) mem[ld_ext[AW-1:0]] <= in_pixel_value;
    if (cmd.read) rd_data_r <= mem[addr_r];
  end

  // raster counters and the latched pixel position
  logic [COORD_BITS-1:0] col_cnt_r, row_cnt_r;
  logic [COORD_BITS-1:0] col_r, row_r;
  logic                  degen_r;
  logic [CW-1:0]         col_inc, row_inc;
  logic                  wrap_col, wrap_row;

  assign col_inc  = CW'(col_r) + 1'b1;
  assign row_inc  = CW'(row_r) + 1'b1;
  assign wrap_col = (col_inc >= CW'(tgt_w_r));
  assign wrap_row = (row_inc >= CW'(tgt_h_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      degen_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        degen_r <= (sw_c == '0) || (sh_c == '0) || (tgt_w_r == '0) || (tgt_h_r == '0);
      end
      if (cmd.emit) begin
        if (degen_r || (wrap_col && wrap_row)) begin
          col_cnt_r <= '0;
          row_cnt_r <= '0;
        end else if (wrap_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= row_inc[COORD_BITS-1:0];
        end else begin
          col_cnt_r <= col_inc[COORD_BITS-1:0];
          row_cnt_r <= row_r;
        end
      end
    end
  end

  // counters beyond the target restart at zero
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_r <= (CW'(col_cnt_r) < CW'(tgt_w_r)) ? col_cnt_r : '0;
      row_r <= (CW'(row_cnt_r) < CW'(tgt_h_r)) ? row_cnt_r : '0;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [PRW-1:0]  prod;
  logic [TDW-1:0]  divisor;
  logic [CMPW-1:0] rem_r, div_r;
  logic [QW-1:0]   q_r, sx_r;
  logic            ge;

  assign prod    = cmd.sel_y ? PRW'(row_r) * PRW'(sh_c) : PRW'(col_r) * PRW'(sw_c);
  assign divisor = cmd.sel_y ? tgt_h_r : tgt_w_r;
  assign ge      = (rem_r >= div_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= CMPW'(prod);
      div_r <= CMPW'(divisor) << (QW - 1);
      q_r   <= '0;
      if (cmd.sel_y) sx_r <= q_r;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - div_r;
      div_r <= div_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  // store address sy * sw + sx, sy sits in the divider quotient
  logic [AFW-1:0] addr_full;
  assign addr_full = AFW'(q_r) * AFW'(sw_c) + AFW'(sx_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_addr) addr_r <= addr_full[AW-1:0];
  end

  // framebuffer position and clipping
  logic signed [PW-1:0] px, py;
  logic                 in_x, in_y;

  assign px   = PW'($signed(org_x_r)) + $signed(PW'(col_r));
  assign py   = PW'($signed(org_y_r)) + $signed(PW'(row_r));
  assign in_x = (px[PW-1:COORD_BITS] == '0) && (px[PW-2:0] < (PW-1)'(scr_w_r));
  assign in_y = (py[PW-1:COORD_BITS] == '0) && (py[PW-2:0] < (PW-1)'(scr_h_r));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (degen_r) begin
        out_screen_x     <= '0;
        out_screen_y     <= '0;
        out_color        <= '0;
        out_write_enable <= 1'b0;
        out_last         <= 1'b1;
      end else begin
        out_screen_x     <= px[COORD_BITS-1:0];
        out_screen_y     <= py[COORD_BITS-1:0];
        out_color        <= rd_data_r;
        out_write_enable <= in_x && in_y;
        out_last         <= wrap_col && wrap_row;
      end
    end
  end

  assign sts.degenerate = degen_r;
  assign sts.out_free   = !out_valid || out_ready;

  // checks
  a_emit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted beat did not reach the output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_color) && $stable(out_last)))
    else $error("waiting output beat changed");

  a_degenerate_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.degenerate) |=> (out_last && !out_write_enable))
    else $error("empty frame beat not flagged as last");

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_neighbor_image_scaler_unit.sv -----
// Sequence: an accepted step beat runs the x and then the y product and division
// on the shared divider, then the address, store read and output states; a beat
// with any size zero goes from the x product state straight to output. A load
// beat writes the store on acceptance. No beat is accepted until the output state
// hands off; a held output register adds its wait on out_ready.
// Reset: synchronous active-low rst_n clears registers, counters and control;
// the source store holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit
// Top level: loads source pixels into a store and produces scaled destination
// pixels in raster order with framebuffer clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_scaler_unit #(
  parameter int MAX_SOURCE_WIDTH  = nnis_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_SOURCE_HEIGHT = nnis_pkg::MAX_SOURCE_HEIGHT_DEF,
  parameter int COORD_BITS        = nnis_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [nnis_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [nnis_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_cmd,
  input  wire logic [nnis_pkg::LOAD_INDEX_BITS-1:0]  in_load_index,
  input  wire logic [nnis_pkg::PIXEL_BITS-1:0]       in_pixel_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [COORD_BITS-1:0]                      out_screen_x,
  output logic [COORD_BITS-1:0]                      out_screen_y,
  output logic [nnis_pkg::PIXEL_BITS-1:0]            out_color,
  output logic                                       out_write_enable,
  output logic                                       out_last
);

  nnis_pkg::dp_cmd_t cmd;
  nnis_pkg::dp_sts_t sts;

  // controller
  nnis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath
  nnis_datapath #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .COORD_BITS        (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_load_index    (in_load_index),
    .in_pixel_value   (in_pixel_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_color        (out_color),
    .out_write_enable (out_write_enable),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
